// ===== hdl/mcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpq_pkg
// shared widths and result status codes for the min-cost priority queue
// ----------------------------------------------------------------------------
package mcpq_pkg;

    localparam int ID_BITS     = 16;
    localparam int STATUS_BITS = 2;
    localparam int APB_DW      = 32;

    typedef logic [STATUS_BITS-1:0] t_status;

    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_NONE = 2'd2;

endpackage

// ===== hdl/mcpq_store.sv =====
// ----------------------------------------------------------------------------
// mcpq_store
// entry memory holding {id, cost} pairs, one write and one registered read
// ----------------------------------------------------------------------------
module mcpq_store
    import mcpq_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int COST_BITS = 24,
    parameter int AW        = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [ID_BITS+COST_BITS-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [ID_BITS+COST_BITS-1:0] o_rdata
);

    logic [ID_BITS+COST_BITS-1:0] r_mem [DEPTH];
    logic [ID_BITS+COST_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/min_cost_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// min_cost_priority_queue_top
// arrival-order priority queue: insert appends, extract takes the first
// lowest-cost entry below the cost ceiling and closes the gap
// ----------------------------------------------------------------------------
// sequence: insert appends and strobes its result; extract scans all stored
//   entries, then compacts the entries behind the taken position pos, then strobes
// throughput: one item at a time through the one shared read port; busy drops
//   as the strobe shows, so the next start may be taken then; no output stall
// reset (synchronous, active low) empties the queue, restores the ceiling
// ----------------------------------------------------------------------------
module min_cost_priority_queue_top
    import mcpq_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int COST_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command side
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_kind,
    input  logic [ID_BITS-1:0]             i_item_id,
    input  logic [COST_BITS-1:0]           i_item_cost,
    // result side
    output logic                           o_done,
    output logic [STATUS_BITS-1:0]         o_status,
    output logic [ID_BITS-1:0]             o_out_id,
    output logic [COST_BITS-1:0]           o_out_cost,
    output logic [$clog2(DEPTH+1)-1:0]     o_occupancy,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [APB_DW-1:0]              pwdata,
    output logic [APB_DW-1:0]              prdata,
    output logic                           pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int EW = ID_BITS + COST_BITS;

    localparam logic [COST_BITS-1:0] CEIL_RESET = COST_BITS'(24'hFF_FFFF);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INS   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    // control registers
    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_addr,  n_addr;     // next read address
    logic                 r_rv,    n_rv;       // read data valid this cycle
    logic                 r_found, n_found;
    logic                 r_done,  n_done;
    logic [COST_BITS-1:0] r_ceiling;

    // payload registers
    logic [AW-1:0]        r_ridx,    n_ridx;   // index of the data now read
    logic [AW-1:0]        r_pos,     n_pos;
    logic [COST_BITS-1:0] r_best,    n_best;
    logic [ID_BITS-1:0]   r_best_id, n_best_id;
    logic [ID_BITS-1:0]   r_in_id;
    logic [COST_BITS-1:0] r_in_cost;
    t_status              r_status,  n_status;
    logic [ID_BITS-1:0]   r_out_id,  n_out_id;
    logic [COST_BITS-1:0] r_out_cost, n_out_cost;
    logic [CW-1:0]        r_occ,     n_occ;

    // memory interface
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;
    logic                 w_issue;
    logic [EW-1:0]        w_rdata;
    logic [COST_BITS-1:0] w_rd_cost;
    logic [ID_BITS-1:0]   w_rd_id;

    logic w_accept;
    logic w_cfg_wr;
    logic w_full;

    assign w_accept  = start && !busy;
    assign w_cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_rd_cost = w_rdata[COST_BITS-1:0];
    assign w_rd_id   = w_rdata[EW-1:COST_BITS];

    // scan and compaction share the one read port, one address per cycle
    assign w_issue = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_addr < r_count);

    mcpq_store #(
        .DEPTH     (DEPTH),
        .COST_BITS (COST_BITS),
        .AW        (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = w_issue ? (r_addr + 1'b1) : r_addr;
        n_rv       = w_issue;
        n_ridx     = r_addr[AW-1:0];
        n_found    = r_found;
        n_done     = 1'b0;
        n_pos      = r_pos;
        n_best     = r_best;
        n_best_id  = r_best_id;
        n_status   = r_status;
        n_out_id   = r_out_id;
        n_out_cost = r_out_cost;
        n_occ      = r_occ;
        w_we       = 1'b0;
        w_waddr    = r_count[AW-1:0];
        w_wdata    = {r_in_id, r_in_cost};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_best  = r_ceiling;
                    n_state = i_kind ? S_SCAN : S_INS;
                end
            end
            S_INS: begin
                // append at the tail unless the store is full
                n_out_id   = '0;
                n_out_cost = '0;
                n_done     = 1'b1;
                n_state    = S_IDLE;
                if (w_full) begin
                    n_status = ST_FULL;
                    n_occ    = r_count;
                end else begin
                    w_we     = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_status = ST_DONE;
                    n_occ    = r_count + 1'b1;
                end
            end
            S_SCAN: begin
                // strict less-than keeps the earliest of equal costs
                if (r_rv && (w_rd_cost < r_best)) begin
                    n_best    = w_rd_cost;
                    n_best_id = w_rd_id;
                    n_pos     = r_ridx;
                    n_found   = 1'b1;
                end
                if (!w_issue && !r_rv) begin
                    if (r_found) begin
                        n_addr  = CW'(r_pos) + 1'b1;
                        n_state = S_SHIFT;
                    end else begin
                        n_status   = ST_NONE;
                        n_out_id   = '0;
                        n_out_cost = '0;
                        n_occ      = r_count;
                        n_done     = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                // each entry behind the taken one moves up one place
                if (r_rv) begin
                    w_we    = 1'b1;
                    w_waddr = r_ridx - 1'b1;
                    w_wdata = w_rdata;
                end
                if (!w_issue && !r_rv) begin
                    n_count    = r_count - 1'b1;
                    n_status   = ST_DONE;
                    n_out_id   = r_best_id;
                    n_out_cost = r_best;
                    n_occ      = r_count - 1'b1;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_rv      <= 1'b0;
            r_found   <= 1'b0;
            r_done    <= 1'b0;
            r_ceiling <= CEIL_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_rv    <= n_rv;
            r_found <= n_found;
            r_done  <= n_done;
            if (w_cfg_wr) begin
                r_ceiling <= pwdata[COST_BITS-1:0];
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_ridx     <= n_ridx;
        r_pos      <= n_pos;
        r_best     <= n_best;
        r_best_id  <= n_best_id;
        r_status   <= n_status;
        r_out_id   <= n_out_id;
        r_out_cost <= n_out_cost;
        r_occ      <= n_occ;
        if (w_accept) begin
            r_in_id   <= i_item_id;
            r_in_cost <= i_item_cost;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_cost  = r_out_cost;
    assign o_occupancy = r_occ;

    // register readback, only the ceiling is mapped
    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : APB_DW'(r_ceiling);

    // checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_occupancy <= CW'(DEPTH)))
        else $error("occupancy above depth");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_DONE)) |-> ((o_out_id == '0) && (o_out_cost == '0)))
        else $error("payload not zero on a failed item");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe outside end of operation");

endmodule
